FILE: hw/rtl/wcts_pkg.sv
// ----------------------------------------------------------------------------
// wcts_pkg: shared types and constants
// Widths, register indexes and sequencer types for the wall column stepper.
// ----------------------------------------------------------------------------
package wcts_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_TEX_LOG2 = 12;

    localparam int TEX_LOG2_W = 4;
    localparam int SCREEN_H_W = 13;
    localparam int COL_W      = 12;
    localparam int WALL_W     = 16;
    localparam int LH_W       = 16;
    localparam int DS_W       = 12;
    localparam int ROW_W      = 13;
    localparam int TEX_W      = 12;
    localparam int ADDR_W     = 24;
    localparam int TEXID_W    = 2;
    localparam int STEP_W     = 32;
    localparam int POS_W      = 48;

    // divide: dividend is 1 << (log2 + FRAC_BITS)
    localparam int DIV_BITS = FRAC_BITS + MAX_TEX_LOG2 + 1;
    // start offset magnitude
    localparam int OFF_W    = 17;
    localparam int CNT_W    = $clog2(DIV_BITS);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SCREEN_H_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_LOG2 = 1'b0,
        CFG_SCREEN_H = 1'b1
    } t_cfg_idx;

    typedef enum logic [TEXID_W-1:0] {
        TEX_NORTH = 2'd0,
        TEX_SOUTH = 2'd1,
        TEX_EAST  = 2'd2,
        TEX_WEST  = 2'd3
    } t_tex_id;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_DIV,
        SEQ_MUL,
        SEQ_DONE
    } t_seq_state;

    typedef struct packed {
        logic                  start;
        logic [TEX_LOG2_W-1:0] log2;
        logic [LH_W-1:0]       line_height;
        logic [OFF_W-1:0]      off_mag;
    } t_seq_req;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] step;
        logic [POS_W-1:0]    prod;
    } t_seq_rsp;

    typedef struct packed {
        logic [POS_W-1:0] a;
        logic [POS_W-1:0] b;
        logic             cin;
    } t_alu_req;

endpackage

FILE: hw/rtl/wcts_if.sv
// ----------------------------------------------------------------------------
// wcts interfaces: request, result and configuration channels
// Valid/ready channels carrying the stepper payloads.
// ----------------------------------------------------------------------------
interface wcts_in_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [wcts_pkg::COL_W-1:0]       column;
    logic                             hit_side;
    logic                             ray_dir_positive;
    logic [wcts_pkg::WALL_W-1:0]      wall_pos;
    logic [wcts_pkg::LH_W-1:0]        line_height;
    logic [wcts_pkg::DS_W-1:0]        span_start;
    logic [wcts_pkg::ROW_W-1:0]       span_end;

    modport source (output valid, action, column, hit_side, ray_dir_positive,
                    wall_pos, line_height, span_start, span_end, input ready);
    modport sink   (input valid, action, column, hit_side, ray_dir_positive,
                    wall_pos, line_height, span_start, span_end, output ready);
endinterface

interface wcts_out_if;
    logic                             valid;
    logic                             ready;
    logic [wcts_pkg::COL_W-1:0]       out_column;
    logic [wcts_pkg::TEX_W-1:0]       row;
    logic [wcts_pkg::TEXID_W-1:0]     texture_id;
    logic [wcts_pkg::TEX_W-1:0]       tex_x;
    logic [wcts_pkg::TEX_W-1:0]       tex_y;
    logic [wcts_pkg::ADDR_W-1:0]      texel_address;
    logic                             last_row;

    modport source (output valid, out_column, row, texture_id, tex_x, tex_y,
                    texel_address, last_row, input ready);
    modport sink   (input valid, out_column, row, texture_id, tex_x, tex_y,
                    texel_address, last_row, output ready);
endinterface

interface wcts_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [wcts_pkg::CFG_IDX_W-1:0]    index;
    logic [wcts_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/wcts_alu.sv
// ----------------------------------------------------------------------------
// wcts_alu: shared adder
// One wide add with carry in/out, used for divide trials and multiply steps.
// ----------------------------------------------------------------------------
module wcts_alu (
    input  wcts_pkg::t_alu_req              i_req,
    output logic [wcts_pkg::POS_W-1:0]      o_sum,
    output logic                            o_cout
);
    logic [wcts_pkg::POS_W:0] w_sum;

    assign w_sum  = {1'b0, i_req.a} + {1'b0, i_req.b}
                  + {{wcts_pkg::POS_W{1'b0}}, i_req.cin};
    assign o_sum  = w_sum[wcts_pkg::POS_W-1:0];
    assign o_cout = w_sum[wcts_pkg::POS_W];
endmodule

FILE: hw/rtl/wcts_seq.sv
// ----------------------------------------------------------------------------
// wcts_seq: step and start position sequencer
// Restoring divide for the step, then shift-add multiply of the offset,
// both on the shared adder.
// ----------------------------------------------------------------------------
module wcts_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wcts_pkg::t_seq_req   i_req,
    output wcts_pkg::t_seq_rsp   o_rsp
);
    wcts_pkg::t_seq_state r_state, n_state;

    logic [wcts_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [wcts_pkg::LH_W-1:0]       r_rem, n_rem;
    logic [wcts_pkg::DIV_BITS-1:0]   r_quo, n_quo;
    logic [wcts_pkg::LH_W-1:0]       r_div;
    logic [wcts_pkg::TEX_LOG2_W-1:0] r_log2;
    logic [wcts_pkg::OFF_W-1:0]      r_mplier, n_mplier;
    logic [wcts_pkg::POS_W-1:0]      r_mcand, n_mcand;
    logic [wcts_pkg::POS_W-1:0]      r_acc, n_acc;

    wcts_pkg::t_alu_req              w_alu;
    logic [wcts_pkg::POS_W-1:0]      w_sum;
    logic                            w_cout;
    logic                            w_dbit;
    logic [wcts_pkg::LH_W:0]         w_trial;

    wcts_alu u_alu (
        .i_req  (w_alu),
        .o_sum  (w_sum),
        .o_cout (w_cout)
    );

    // dividend is a single one bit at log2 + FRAC_BITS
    assign w_dbit  = (r_cnt == (wcts_pkg::CNT_W'(r_log2)
                              + wcts_pkg::CNT_W'(wcts_pkg::FRAC_BITS)));
    assign w_trial = {r_rem, w_dbit};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_mplier = r_mplier;
        n_mcand  = r_mcand;
        n_acc    = r_acc;
        w_alu.a   = r_acc;
        w_alu.b   = r_mcand & {wcts_pkg::POS_W{r_mplier[0]}};
        w_alu.cin = 1'b0;
        unique case (r_state)
            wcts_pkg::SEQ_IDLE: begin
                if (i_req.start) begin
                    n_state  = wcts_pkg::SEQ_DIV;
                    n_cnt    = wcts_pkg::CNT_W'(wcts_pkg::DIV_BITS - 1);
                    n_rem    = '0;
                    n_quo    = '0;
                    n_mplier = i_req.off_mag;
                    n_acc    = '0;
                end
            end
            wcts_pkg::SEQ_DIV: begin
                // trial subtract: trial - divisor, carry out means no borrow
                w_alu.a   = wcts_pkg::POS_W'(w_trial);
                w_alu.b   = ~wcts_pkg::POS_W'(r_div);
                w_alu.cin = 1'b1;
                n_rem = w_cout ? w_sum[wcts_pkg::LH_W-1:0] : w_trial[wcts_pkg::LH_W-1:0];
                n_quo = {r_quo[wcts_pkg::DIV_BITS-2:0], w_cout};
                if (r_cnt == '0) begin
                    n_state = wcts_pkg::SEQ_MUL;
                    n_cnt   = wcts_pkg::CNT_W'(wcts_pkg::OFF_W - 1);
                    n_mcand = wcts_pkg::POS_W'(n_quo);
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            wcts_pkg::SEQ_MUL: begin
                n_acc    = w_sum;
                n_mcand  = {r_mcand[wcts_pkg::POS_W-2:0], 1'b0};
                n_mplier = r_mplier >> 1;
                if (r_cnt == '0) begin
                    n_state = wcts_pkg::SEQ_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            wcts_pkg::SEQ_DONE: begin
                n_state = wcts_pkg::SEQ_IDLE;
            end
            default: begin
                n_state = wcts_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wcts_pkg::SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_mplier <= n_mplier;
        r_mcand  <= n_mcand;
        r_acc    <= n_acc;
        if (r_state == wcts_pkg::SEQ_IDLE && i_req.start) begin
            r_div  <= i_req.line_height;
            r_log2 <= i_req.log2;
        end
    end

    assign o_rsp.done = (r_state == wcts_pkg::SEQ_DONE);
    assign o_rsp.step = r_quo;
    assign o_rsp.prod = r_acc;
endmodule

FILE: hw/rtl/wall_column_texel_stepper_top.sv
// ----------------------------------------------------------------------------
// wall_column_texel_stepper_top: textured wall column to texel coordinates
// Column setup on a shared-adder sequencer, then one pixel per row request.
// ----------------------------------------------------------------------------
// A start request (action 0) sets up one wall column: it latches the column,
// picks the texture, forms tex_x, and runs the sequencer, which divides the
// texture size by the line height one quotient bit per cycle and then
// multiplies the start offset by that step one bit per cycle on the same
// adder; the input is held not ready until the sequencer is done, and the
// start request produces no result. A row request (action 1) is taken
// whenever the sequencer is idle and the output register is empty or being
// drained, so rows stream one per cycle; a row past the end of the column
// is taken and gives no result. Configuration writes are accepted at any
// time but must only be made while the block is idle. Texture log2 values
// above 12 act as 12.
// ----------------------------------------------------------------------------
module wall_column_texel_stepper_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wcts_cfg_if.sink        i_cfg,
    wcts_in_if.sink         i_in,
    wcts_out_if.source      o_out
);
    // configuration
    logic [wcts_pkg::TEX_LOG2_W-1:0] r_tex_log2;
    logic [wcts_pkg::SCREEN_H_W-1:0] r_screen_h;

    // column state
    logic [wcts_pkg::COL_W-1:0]      r_column;
    logic [wcts_pkg::TEXID_W-1:0]    r_texture;
    logic [wcts_pkg::TEX_W-1:0]      r_tex_x;
    logic [wcts_pkg::STEP_W-1:0]     r_step;
    logic [wcts_pkg::POS_W-1:0]      r_pos;
    logic [wcts_pkg::ROW_W-1:0]      r_row;
    logic [wcts_pkg::ROW_W-1:0]      r_end_row;
    logic                            r_off_neg;
    logic                            r_busy;

    // result register
    logic                            r_out_valid;
    logic [wcts_pkg::COL_W-1:0]      r_out_column;
    logic [wcts_pkg::TEX_W-1:0]      r_out_row;
    logic [wcts_pkg::TEXID_W-1:0]    r_out_texture;
    logic [wcts_pkg::TEX_W-1:0]      r_out_tex_x;
    logic [wcts_pkg::TEX_W-1:0]      r_out_tex_y;
    logic [wcts_pkg::ADDR_W-1:0]     r_out_addr;
    logic                            r_out_last;

    logic [wcts_pkg::TEX_LOG2_W-1:0] w_log2;
    logic [wcts_pkg::TEX_W-1:0]      w_mask;
    logic                            w_accept;
    logic                            w_start;
    logic                            w_row_go;
    logic [wcts_pkg::LH_W-1:0]       w_lh;
    logic signed [wcts_pkg::OFF_W:0] w_off;
    logic [wcts_pkg::TEX_W-1:0]      w_tx_raw;
    logic [wcts_pkg::TEX_W-1:0]      w_tex_y;
    logic [wcts_pkg::ADDR_W-1:0]     w_addr;
    wcts_pkg::t_seq_req              w_seq_req;
    wcts_pkg::t_seq_rsp              w_seq_rsp;

    assign i_cfg.ready = 1'b1;

    // clamp texture log2, mask is size - 1
    assign w_log2 = (r_tex_log2 > wcts_pkg::TEX_LOG2_W'(wcts_pkg::MAX_TEX_LOG2))
                  ? wcts_pkg::TEX_LOG2_W'(wcts_pkg::MAX_TEX_LOG2) : r_tex_log2;
    assign w_mask = wcts_pkg::TEX_W'((wcts_pkg::ADDR_W'(1) << w_log2) - 1'b1);

    assign i_in.ready = !r_busy && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_start    = w_accept && !i_in.action;
    assign w_row_go   = w_accept && i_in.action && (r_row < r_end_row);

    // start offset: span_start - screen_height/2 + line_height/2
    assign w_lh  = (i_in.line_height == '0) ? wcts_pkg::LH_W'(1) : i_in.line_height;
    assign w_off = $signed({1'b0, wcts_pkg::OFF_W'(i_in.span_start)})
                 - $signed({1'b0, wcts_pkg::OFF_W'(r_screen_h >> 1)})
                 + $signed({1'b0, wcts_pkg::OFF_W'(w_lh >> 1)});

    assign w_seq_req.start       = w_start;
    assign w_seq_req.log2        = w_log2;
    assign w_seq_req.line_height = w_lh;
    assign w_seq_req.off_mag     = w_off[wcts_pkg::OFF_W]
                                 ? wcts_pkg::OFF_W'(-w_off) : wcts_pkg::OFF_W'(w_off);

    wcts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_seq_req),
        .o_rsp   (w_seq_rsp)
    );

    // tex_x = floor(wall_pos * size / 2^16); mirror is mask xor
    assign w_tx_raw = wcts_pkg::TEX_W'(i_in.wall_pos >> (wcts_pkg::WALL_W - 32'(w_log2)));

    // row datapath
    assign w_tex_y = r_pos[wcts_pkg::FRAC_BITS +: wcts_pkg::TEX_W] & w_mask;
    assign w_addr  = (wcts_pkg::ADDR_W'(w_tex_y) << w_log2) + wcts_pkg::ADDR_W'(r_tex_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_log2  <= wcts_pkg::TEX_LOG2_W'(6);
            r_screen_h  <= wcts_pkg::SCREEN_H_W'(480);
            r_column    <= '0;
            r_texture   <= '0;
            r_tex_x     <= '0;
            r_step      <= '0;
            r_pos       <= '0;
            r_row       <= '0;
            r_end_row   <= '0;
            r_off_neg   <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (wcts_pkg::t_cfg_idx'(i_cfg.index))
                    wcts_pkg::CFG_TEX_LOG2: r_tex_log2 <= i_cfg.data[wcts_pkg::TEX_LOG2_W-1:0];
                    wcts_pkg::CFG_SCREEN_H: r_screen_h <= i_cfg.data;
                    default: ;
                endcase
            end

            if (w_start) begin
                r_busy    <= 1'b1;
                r_off_neg <= w_off[wcts_pkg::OFF_W];
                r_column  <= i_in.column;
                r_row     <= wcts_pkg::ROW_W'(i_in.span_start);
                r_end_row <= i_in.span_end;
                if (i_in.hit_side) begin
                    r_texture <= i_in.ray_dir_positive ? wcts_pkg::TEX_NORTH
                                                       : wcts_pkg::TEX_SOUTH;
                end else begin
                    r_texture <= i_in.ray_dir_positive ? wcts_pkg::TEX_EAST
                                                       : wcts_pkg::TEX_WEST;
                end
                // east and south hits read the texture mirrored
                r_tex_x <= (i_in.hit_side ^ i_in.ray_dir_positive)
                         ? (w_tx_raw ^ w_mask) : w_tx_raw;
            end

            if (w_seq_rsp.done) begin
                r_busy <= 1'b0;
                r_step <= wcts_pkg::STEP_W'(w_seq_rsp.step);
                r_pos  <= r_off_neg ? (~w_seq_rsp.prod + 1'b1) : w_seq_rsp.prod;
            end

            if (w_row_go) begin
                r_out_valid <= 1'b1;
                r_pos       <= r_pos + wcts_pkg::POS_W'(r_step);
                r_row       <= r_row + 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_row_go) begin
            r_out_column  <= r_column;
            r_out_row     <= r_row[wcts_pkg::TEX_W-1:0];
            r_out_texture <= r_texture;
            r_out_tex_x   <= r_tex_x;
            r_out_tex_y   <= w_tex_y;
            r_out_addr    <= w_addr;
            r_out_last    <= ((r_row + 1'b1) == r_end_row);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_column    = r_out_column;
    assign o_out.row           = r_out_row;
    assign o_out.texture_id    = r_out_texture;
    assign o_out.tex_x         = r_out_tex_x;
    assign o_out.tex_y         = r_out_tex_y;
    assign o_out.texel_address = r_out_addr;
    assign o_out.last_row      = r_out_last;
endmodule
